[rtl/rmvm_pkg.sv]
// Shared constants, state encoding and controller/datapath interface types.
package rmvm_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int SQ_BITS         = 64;
   localparam int DIGIT_BITS      = 8;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_PREP = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_SUM  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic prep;
      logic mul_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic step_last;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/rmvm_ctrl.sv]
// Sequencer that steps one sample through divide, multiply and accumulate.
module rmvm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rmvm_pkg::dp_status_type status,
   output rmvm_pkg::ctrl_cmd_type  cmd
);
   import rmvm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      out_wait;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_wait = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // The result waits here for a free output; the running sum is updated once, as the result is loaded.
            out_wait = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !status.step_last) |=> (state_ff == ST_DIV))
      else $error("divider left before its last step");

   a_wait_out: assert property (@(posedge clock) disable iff (reset)
      (out_wait && !status.out_free) |=> (state_ff == ST_SUM))
      else $error("result dropped while output was full");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule

[rtl/rmvm_dp.sv]
// Datapath: statistics registers, bit-serial divider, digit multiplier and output register.
module rmvm_dp #(
   parameter int SAMPLE_BITS = rmvm_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = rmvm_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS  = rmvm_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmvm_pkg::ctrl_cmd_type               cmd,
   output rmvm_pkg::dp_status_type              status,
   input  logic                                 track_max,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]     rsp_mean_q16,
   output logic [rmvm_pkg::SQ_BITS-1:0]         rsp_sq_dev_sum,
   output logic [SAMPLE_BITS-1:0]               rsp_largest,
   output logic [COUNT_BITS-1:0]                rsp_sample_count
);
   import rmvm_pkg::*;

   localparam int M        = SAMPLE_BITS + FRAC_BITS;
   localparam int K        = (M + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DW       = K * DIGIT_BITS;
   localparam int P        = M + DW;
   localparam int EXT      = P + SQ_BITS + 2 * FRAC_BITS;
   localparam int CNT_BITS = $clog2(M);

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [M-1:0]           mean_ff, mean_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic                   up_ff, up_in;
   logic [M-1:0]           d1_ff, d1_in;
   logic [M-1:0]           quo_ff, quo_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [DW-1:0]          d2_ff, d2_in;
   logic [P-1:0]           acc_ff, acc_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [M-1:0]           rsp_mean_ff;
   logic [SQ_BITS-1:0]     rsp_sq_ff;
   logic [SAMPLE_BITS-1:0] rsp_max_ff;
   logic [COUNT_BITS-1:0]  rsp_count_ff;

   logic [COUNT_BITS-1:0]  base_count;
   logic [M-1:0]           base_mean;
   logic [SAMPLE_BITS-1:0] base_max;
   logic [M-1:0]           xq;
   logic                   up_now;
   logic [COUNT_BITS:0]    div_shifted;
   logic [COUNT_BITS:0]    div_diff;
   logic                   div_ge;
   logic [M+DIGIT_BITS-1:0] pp;
   logic [EXT-1:0]         prod_ext;
   logic [SQ_BITS-1:0]     inc;
   logic [SQ_BITS:0]       sq_sum;

   assign base_count = req_restart ? '0 : count_ff;
   assign base_mean  = req_restart ? '0 : mean_ff;
   assign base_max   = req_restart ? '0 : max_ff;
   assign xq         = {req_sample, {FRAC_BITS{1'b0}}};
   assign up_now     = (xq >= base_mean);

   assign div_shifted = {rem_ff, quo_ff[M-1]};
   assign div_diff    = div_shifted - {1'b0, count_ff};
   assign div_ge      = (div_shifted >= {1'b0, count_ff});

   assign pp = (M + DIGIT_BITS)'(d1_ff) * (M + DIGIT_BITS)'(d2_ff[DW-1 -: DIGIT_BITS]);

   assign prod_ext = EXT'(acc_ff) >> (2 * FRAC_BITS);
   assign inc      = (|prod_ext[EXT-1:SQ_BITS]) ? '1 : prod_ext[SQ_BITS-1:0];
   assign sq_sum   = {1'b0, sq_ff} + {1'b0, inc};

   assign status.step_last = (cnt_ff == '0);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in     = count_ff;
      mean_in      = mean_ff;
      sq_in        = sq_ff;
      max_in       = max_ff;
      up_in        = up_ff;
      d1_in        = d1_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      d2_in        = d2_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         count_in = (&base_count) ? base_count : base_count + 1'b1;
         mean_in  = base_mean;
         sq_in    = req_restart ? '0 : sq_ff;
         max_in   = (track_max && (req_sample > base_max)) ? req_sample : base_max;
         up_in    = up_now;
         d1_in    = up_now ? xq - base_mean : base_mean - xq;
         quo_in   = up_now ? xq - base_mean : base_mean - xq;
         rem_in   = '0;
         cnt_in   = CNT_BITS'(M - 1);
      end
      if (cmd.div_step) begin
         rem_in = div_ge ? div_diff[COUNT_BITS-1:0] : div_shifted[COUNT_BITS-1:0];
         quo_in = {quo_ff[M-2:0], div_ge};
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.prep) begin
         mean_in = up_ff ? mean_ff + quo_ff : mean_ff - quo_ff;
         d2_in   = DW'(d1_ff - quo_ff);
         acc_in  = '0;
         cnt_in  = CNT_BITS'(K - 1);
      end
      if (cmd.mul_step) begin
         acc_in = (acc_ff << DIGIT_BITS) + P'(pp);
         d2_in  = d2_ff << DIGIT_BITS;
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.out_load) begin
         sq_in        = sq_sum[SQ_BITS] ? '1 : sq_sum[SQ_BITS-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mean_ff      <= '0;
         sq_ff        <= '0;
         max_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         sq_ff        <= sq_in;
         max_ff       <= max_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff  <= up_in;
      d1_ff  <= d1_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      d2_ff  <= d2_in;
      acc_ff <= acc_in;
      if (cmd.out_load) begin
         rsp_mean_ff  <= mean_ff;
         rsp_sq_ff    <= sq_in;
         rsp_max_ff   <= max_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_q16     = rsp_mean_ff;
   assign rsp_sq_dev_sum   = rsp_sq_ff;
   assign rsp_largest      = rsp_max_ff;
   assign rsp_sample_count = rsp_count_ff;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (count_ff != '0))
      else $error("sample count is zero after a sample was taken");

   a_rem_below_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (rem_ff < count_ff))
      else $error("divider remainder not below the count");

   a_sq_monotonic: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (sq_ff >= $past(sq_ff)))
      else $error("squared-deviation sum decreased");

endmodule

[rtl/running_mean_variance_max_top.sv]
// Top level of the running mean, variance and maximum accumulator.
// Each sample goes in turn through a load step, the restoring divider, a prepare step, the
// digit multiplier and a final sum step: its result can be taken once it sits in the output
// register, and the next sample can be accepted at the same point. The restoring divider
// produces one quotient bit of (sample - mean) / count per cycle. The divider is
// followed by a multiplier that takes eight bits of the second deviation per cycle. One sample
// is worked on at a time; the finished result sits in an output register, so the next sample
// is accepted while that result still waits to be taken. If an earlier result is still held
// there, the block waits in its last step until that result is taken. The track_max register
// is written through the csr port, which is always ready, and should only be written while no
// sample is in flight.
module running_mean_variance_max_top #(
   parameter int SAMPLE_BITS = rmvm_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = rmvm_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS  = rmvm_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0] rsp_mean_q16,
   output logic [rmvm_pkg::SQ_BITS-1:0]     rsp_sq_dev_sum,
   output logic [SAMPLE_BITS-1:0]           rsp_largest,
   output logic [COUNT_BITS-1:0]            rsp_sample_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_track_max
);
   import rmvm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          track_max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_max_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         track_max_ff <= csr_track_max;
      end
   end

   rmvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rmvm_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .track_max        (track_max_ff),
      .req_sample       (req_sample),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_q16     (rsp_mean_q16),
      .rsp_sq_dev_sum   (rsp_sq_dev_sum),
      .rsp_largest      (rsp_largest),
      .rsp_sample_count (rsp_sample_count)
   );

endmodule

[dv/running_mean_variance_max_tb.sv]
// Self-checking testbench for the running mean, variance and maximum accumulator.
module testbench;

   localparam int SAMPLE_W     = rmvm_pkg::SAMPLE_BITS_DEF;
   localparam int FRAC_W       = rmvm_pkg::FRAC_BITS_DEF;
   localparam int COUNT_W      = rmvm_pkg::COUNT_BITS_DEF;
   localparam int SQ_W         = rmvm_pkg::SQ_BITS;
   localparam int MEAN_W       = SAMPLE_W + FRAC_W;
   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   localparam int LATENCY      = 64;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TIMEOUT      = 2_000_000;

   localparam bit LARGEST_HOLD = 1'b0;
   localparam bit LARGEST_KEEP = 1'b1;

   typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES, SPREAD_LOW} spread_type;

   typedef struct packed {
      logic [MEAN_W-1:0]   mean;
      logic [SQ_W-1:0]     sq_dev;
      logic [SAMPLE_W-1:0] largest;
      logic [COUNT_W-1:0]  count;
   } stats_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [MEAN_W-1:0]   rsp_mean_q16;
   logic [SQ_W-1:0]     rsp_sq_dev_sum;
   logic [SAMPLE_W-1:0] rsp_largest;
   logic [COUNT_W-1:0]  rsp_sample_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_track_max = 1'b0;

   // Shadow of the accumulator state and its configuration.
   logic [COUNT_W-1:0]  acc_count = '0;
   logic [MEAN_W-1:0]   acc_mean = '0;
   logic [SQ_W-1:0]     acc_sq_dev = '0;
   logic [SAMPLE_W-1:0] acc_largest = '0;
   bit                  keep_largest = LARGEST_KEEP;

   stats_type pending_stats[$];
   bit        idling_on = 1'b1;
   int        stall_left = 0;
   int        error_count = 0;
   int        samples_sent = 0;
   int        results_checked = 0;
   int        restarts_sent = 0;
   int        csr_writes = 0;

   running_mean_variance_max_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_q16     (rsp_mean_q16),
      .rsp_sq_dev_sum   (rsp_sq_dev_sum),
      .rsp_largest      (rsp_largest),
      .rsp_sample_count (rsp_sample_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_track_max    (csr_track_max)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   function automatic void predict_stats(input logic [SAMPLE_W-1:0] value, input logic restart);
      logic [MEAN_W-1:0] scaled;
      logic [MEAN_W-1:0] old_mean;
      logic [MEAN_W-1:0] dev_old;
      logic [MEAN_W-1:0] dev_new;
      logic [MEAN_W-1:0] step;
      logic [127:0]      product;
      logic [SQ_W-1:0]   increment;
      logic [SQ_W:0]     total;
      logic              rising;
      stats_type         expected;
      if (restart) begin
         acc_count   = '0;
         acc_mean    = '0;
         acc_sq_dev  = '0;
         acc_largest = '0;
      end
      if (acc_count != '1) acc_count = acc_count + 1'b1;
      if (keep_largest && value > acc_largest) acc_largest = value;
      scaled   = {value, {FRAC_W{1'b0}}};
      old_mean = acc_mean;
      rising   = scaled >= old_mean;
      dev_old  = rising ? scaled - old_mean : old_mean - scaled;
      step     = dev_old / MEAN_W'(acc_count);
      acc_mean = rising ? old_mean + step : old_mean - step;
      dev_new  = rising ? scaled - acc_mean : acc_mean - scaled;
      product  = 128'(dev_old) * 128'(dev_new);
      increment = (product[127:96] != '0) ? '1 : product[95:32];
      total = {1'b0, acc_sq_dev} + {1'b0, increment};
      acc_sq_dev = total[SQ_W] ? '1 : total[SQ_W-1:0];
      expected.mean    = acc_mean;
      expected.sq_dev  = acc_sq_dev;
      expected.largest = acc_largest;
      expected.count   = acc_count;
      pending_stats.push_back(expected);
   endfunction

   // The sender leaves valid high after a beat so that back-to-back samples need no gap.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= value;
      req_restart <= restart;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_stats(value, restart);
      samples_sent++;
      if (restart) restarts_sent++;
   endtask

   task automatic settle_block();
      int waited;
      req_valid <= 1'b0;
      for (waited = 0; pending_stats.size() != 0 && waited < DRAIN_LIMIT; waited++) begin
         @(posedge clock);
      end
      if (pending_stats.size() != 0) begin
         report_mismatch("results never delivered", pending_stats.size(), 0);
         pending_stats.delete();
      end
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_track_max(input bit setting);
      settle_block();
      csr_valid     <= 1'b1;
      csr_track_max <= setting;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid    <= 1'b0;
      keep_largest = setting;
      csr_writes++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input spread_type spread,
                                                       input logic [SAMPLE_W-1:0] centre);
      logic [SAMPLE_W-1:0] offset;
      offset = SAMPLE_W'($urandom_range(0, 255));
      case (spread)
         SPREAD_NARROW: begin
            return $urandom_range(0, 1) ? centre + offset : centre - offset;
         end
         SPREAD_EDGES: begin
            return $urandom_range(0, 1) ? '1 - offset[1:0] : SAMPLE_W'(offset[1:0]);
         end
         SPREAD_LOW: begin
            return offset;
         end
         default: begin
            return SAMPLE_W'($urandom());
         end
      endcase
   endfunction

   task automatic test_field_extremes();
      write_track_max(LARGEST_KEEP);
      send_sample('1, 1'b0);
      send_sample('0, 1'b1);
      send_sample('1, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      send_sample(24'hAAAAAA, 1'b0);
      send_sample(24'h555555, 1'b0);
      send_sample('1, 1'b1);
      send_sample('1, 1'b0);
      send_sample('0, 1'b0);
      send_sample(24'h000001, 1'b0);
   endtask

   task automatic test_restart();
      send_sample(24'd100, 1'b0);
      send_sample(24'd300, 1'b1);
      send_sample(24'd7, 1'b0);
      send_sample(24'd7, 1'b1);
      send_sample(24'd8, 1'b1);
   endtask

   // With tracking off the largest value is frozen, and a restart clears it to zero.
   task automatic test_largest_hold();
      write_track_max(LARGEST_HOLD);
      send_sample(24'd50, 1'b0);
      send_sample('1, 1'b0);
      send_sample(24'd20, 1'b1);
      send_sample(24'hFFFF00, 1'b0);
      write_track_max(LARGEST_KEEP);
      send_sample(24'd10, 1'b0);
   endtask

   task automatic test_random_runs();
      spread_type          spread;
      logic [SAMPLE_W-1:0] centre;
      int                  phase;
      int                  item;
      int                  restart_odds;
      for (phase = 0; phase < 8; phase++) begin
         if (phase == 0) write_track_max(LARGEST_HOLD);
         else if (phase == 1) write_track_max(LARGEST_KEEP);
         else write_track_max(bit'($urandom_range(0, 1)));
         centre       = SAMPLE_W'($urandom());
         restart_odds = $urandom_range(0, 1) ? 4 : 40;
         spread       = spread_type'($urandom_range(0, 3));
         for (item = 0; item < 55; item++) begin
            if ($urandom_range(0, 9) == 0) spread = spread_type'($urandom_range(0, 3));
            send_sample(pick_sample(spread, centre), $urandom_range(1, restart_odds) == 1);
         end
      end
   endtask

   task automatic test_quiet_stream();
      int item;
      settle_block();
      idling_on = 1'b0;
      for (item = 0; item < 89; item++) begin
         send_sample(pick_sample(spread_type'($urandom_range(0, 3)), 24'h800000),
                     $urandom_range(0, 15) == 0);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 16);
      end
      rsp_stall <= idling_on && stall_left > 0;
   end

   always @(posedge clock) begin
      stats_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("result beat with nothing outstanding", rsp_sample_count, 0);
         end else begin
            want = pending_stats.pop_front();
            results_checked++;
            if (rsp_mean_q16 !== want.mean)
               report_mismatch("mean_q16", rsp_mean_q16, want.mean);
            if (rsp_sq_dev_sum !== want.sq_dev)
               report_mismatch("sq_dev_sum", rsp_sq_dev_sum, want.sq_dev);
            if (rsp_largest !== want.largest)
               report_mismatch("largest", rsp_largest, want.largest);
            if (rsp_sample_count !== want.count)
               report_mismatch("sample_count", rsp_sample_count, want.count);
         end
      end
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_restart();
      test_largest_hold();
      test_random_runs();
      test_quiet_stream();
      settle_block();
      $display("Checked %0d results from %0d samples, %0d of them restarts.",
               results_checked, samples_sent, restarts_sent);
      $display("The maximum tracking flag was written %0d times, under random idling.",
               csr_writes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
